FILE: sv/wris_pkg.sv
// ----------------------------------------------------------------------------
// wris_pkg: shared types for the weighted random index select block
// Transfer structs, the walk token handed from cell to cell, size constants.
// ----------------------------------------------------------------------------
package wris_pkg;

	localparam int WRIS_MAX_WEIGHTS = 64;
	localparam int WRIS_WEIGHT_W    = 15;
	localparam int WRIS_OUT_IDX_W   = 6;

	// token widths cover the largest list the block supports (1024 weights)
	localparam int WRIS_TOK_IDX_W  = 10;
	localparam int WRIS_TOK_CNT_W  = 11;
	localparam int WRIS_TOK_ROLL_W = 26;

	localparam logic WRIS_OP_PUSH = 1'b0;
	localparam logic WRIS_OP_DRAW = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] weight;
		logic        [15:0] random_fraction;
	} wris_in_t;

	typedef struct packed {
		logic [WRIS_OUT_IDX_W-1:0] chosen_index;
		logic                      none_found;
	} wris_out_t;

	typedef struct packed {
		logic                              valid;
		logic                              hit;
		logic signed [WRIS_TOK_ROLL_W-1:0] roll;
		logic        [WRIS_TOK_IDX_W-1:0]  idx;
		logic        [WRIS_TOK_CNT_W-1:0]  rem;
	} wris_tok_t;

endpackage

FILE: sv/wris_cell.sv
// ----------------------------------------------------------------------------
// wris_cell: one slot of the weight chain
// Holds one clamped weight and applies it to the walk token passing through.
// ----------------------------------------------------------------------------
module wris_cell import wris_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [WRIS_WEIGHT_W-1:0] wr_data,
	input  wris_tok_t                tok_i,
	output wris_tok_t                tok_o
);

	logic [WRIS_WEIGHT_W-1:0]          w_q;
	logic signed [WRIS_TOK_ROLL_W-1:0] roll_sub;
	wris_tok_t                         tok_d;
	wris_tok_t                         tok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q <= wr_data;
		end
	end

	assign roll_sub = tok_i.roll - $signed({{(WRIS_TOK_ROLL_W-WRIS_WEIGHT_W){1'b0}}, w_q});

	always_comb begin
		tok_d = tok_i;
		// rem counts the slots still inside the list; past it the token just rides
		if (tok_i.valid && !tok_i.hit && tok_i.rem != '0) begin
			tok_d.rem = tok_i.rem - 1'b1;
			if (w_q != '0) begin
				tok_d.roll = roll_sub;
				if (roll_sub[WRIS_TOK_ROLL_W-1] || roll_sub == '0) begin
					tok_d.hit = 1'b1;
					tok_d.idx = WRIS_TOK_IDX_W'(CELL_IDX);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

FILE: sv/weighted_random_index_select_core.sv
// ----------------------------------------------------------------------------
// weighted_random_index_select_core: roulette wheel index selection
// Pushes load clamped weights into a chain of cells; a draw sends a roll token
// down the chain, one cell per cycle, and reports the first index it exhausts.
// ----------------------------------------------------------------------------
// Push: busy stays low, no result.
// Draw with zero total: result strobe in the cycle after the transfer, busy stays low.
// Draw otherwise: busy while the token walks every cell, from the launch register
//   through each cell's register; the result strobe is registered after the last cell.
// Reset empties the list (count and total zero); stored weights are not cleared.
// Results are shown for one cycle only; the receiver cannot stall them.
module weighted_random_index_select_core import wris_pkg::*; #(
	parameter int MAX_WEIGHTS = WRIS_MAX_WEIGHTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  wris_in_t  cmd,
	output logic      done,
	output wris_out_t result
);

	localparam int CW = $clog2(MAX_WEIGHTS + 1);
	localparam int TW = WRIS_WEIGHT_W + $clog2(MAX_WEIGHTS);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            cnt_last_q;
	logic [TW-1:0]            total_q;
	logic                     done_q;
	wris_out_t                result_q;
	wris_tok_t                tok0_q;
	wris_tok_t                chain [0:MAX_WEIGHTS];

	logic                     acc;
	logic                     push_acc;
	logic                     draw_acc;
	logic [WRIS_WEIGHT_W-1:0] wdata;
	logic [TW+15:0]           prod;
	logic [WRIS_TOK_IDX_W-1:0] found;

	assign busy     = (state_q == S_WALK);
	assign acc      = start && !busy;
	assign push_acc = acc && (cmd.opcode == WRIS_OP_PUSH) && (count_q < CW'(MAX_WEIGHTS));
	assign draw_acc = acc && (cmd.opcode == WRIS_OP_DRAW);
	assign wdata    = cmd.weight[15] ? '0 : cmd.weight[14:0];
	assign prod     = cmd.random_fraction * total_q;

	assign chain[0] = tok0_q;

	for (genvar g = 0; g < MAX_WEIGHTS; g++) begin : g_cell
		wris_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr_en  (push_acc && (count_q == CW'(g))),
			.wr_data(wdata),
			.tok_i  (chain[g]),
			.tok_o  (chain[g+1])
		);
	end

	// walk ran off the list without a hit: report the last index
	assign found = chain[MAX_WEIGHTS].hit ? chain[MAX_WEIGHTS].idx
	                                      : WRIS_TOK_IDX_W'(cnt_last_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
			tok0_q  <= '0;
		end else begin
			done_q       <= 1'b0;
			tok0_q.valid <= 1'b0;
			if (draw_acc) begin
				tok0_q.hit  <= 1'b0;
				tok0_q.roll <= $signed({{(WRIS_TOK_ROLL_W-TW){1'b0}}, prod[16 +: TW]});
				tok0_q.idx  <= '0;
				tok0_q.rem  <= WRIS_TOK_CNT_W'(count_q);
			end
			if (push_acc) begin
				count_q <= count_q + 1'b1;
				total_q <= total_q + TW'(wdata);
			end
			unique case (state_q)
				S_IDLE: begin
					if (draw_acc) begin
						count_q <= '0;
						total_q <= '0;
						if (total_q == '0) begin
							done_q <= 1'b1;
						end else begin
							tok0_q.valid <= 1'b1;
							state_q      <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (chain[MAX_WEIGHTS].valid) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (draw_acc) begin
			cnt_last_q <= count_q;
			if (total_q == '0) begin
				result_q.chosen_index <= '0;
				result_q.none_found   <= 1'b1;
			end
		end else if (chain[MAX_WEIGHTS].valid) begin
			result_q.chosen_index <= found[WRIS_OUT_IDX_W-1:0];
			result_q.none_found   <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WEIGHTS))
		else $error("weight count beyond list size");

	a_tok_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_WEIGHTS].valid |-> state_q == S_WALK)
		else $error("walk token outside a walk");

	a_push_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd.opcode == WRIS_OP_PUSH) |=> !done_q)
		else $error("push transfer produced a result");

	a_hit_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !result_q.none_found) |-> $past(chain[MAX_WEIGHTS].valid))
		else $error("index result without a finished walk");

endmodule
